// ===== design/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg: shared types and codes of the conveyor sorting controller
// Holds the input and result word layouts, the controller state codes and
// the belt drive codes.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

  typedef enum logic [3:0] {
    ST_START     = 4'd0,
    ST_STANDBY   = 4'd1,
    ST_READY     = 4'd2,
    ST_TRANSPORT = 4'd3,
    ST_RETURN    = 4'd4,
    ST_BACK      = 4'd5,
    ST_METALCHK  = 4'd6,
    ST_NONMETAL  = 4'd7,
    ST_END       = 4'd8,
    ST_METAL     = 4'd9,
    ST_SLIDE     = 4'd10,
    ST_ERROR     = 4'd11
  } ctl_state_t;

  localparam logic [1:0] DRV_STOP  = 2'd0;
  localparam logic [1:0] DRV_RIGHT = 2'd1;
  localparam logic [1:0] DRV_LEFT  = 2'd2;

  typedef struct packed {
    logic start_released;
    logic item_at_beginning;
    logic item_at_height_sensor;
    logic item_at_metal_sensor;
    logic item_at_end;
    logic metal_found;
    logic passed_slide;
    logic profile_ok;
    logic blink_phase;
  } in_word_t;

  typedef struct packed {
    logic [1:0] drive;
    logic       lamp_green;
    logic       lamp_red;
    logic       lamp_yellow;
    logic       led_start;
    logic       junction_open;
    logic [3:0] mode;
  } out_word_t;

endpackage

`default_nettype wire

// ===== design/csc_next_state.sv =====
// ----------------------------------------------------------------------------
// csc_next_state: controller transition logic
// Picks the next state from the current state and one sensor word; within
// a state the last matching condition wins.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_next_state
  import csc_pkg::*;
(
  input  ctl_state_t state,
  input  in_word_t   word,
  output ctl_state_t state_nxt
);

  always_comb begin
    state_nxt = state;
    case (state)
      ST_START: begin
        state_nxt = ST_STANDBY;
      end
      ST_STANDBY: begin
        if (word.start_released) state_nxt = ST_READY;
      end
      ST_READY: begin
        if (word.start_released) state_nxt = ST_STANDBY;
        if (word.item_at_beginning && !word.item_at_end) state_nxt = ST_TRANSPORT;
        if (word.item_at_height_sensor || word.item_at_metal_sensor) state_nxt = ST_ERROR;
      end
      ST_TRANSPORT: begin
        if (!word.profile_ok) state_nxt = ST_RETURN;
        if (word.item_at_metal_sensor) state_nxt = ST_METALCHK;
        if (word.item_at_end) state_nxt = ST_ERROR;
      end
      ST_RETURN: begin
        if (word.item_at_beginning) state_nxt = ST_BACK;
      end
      ST_BACK: begin
        if (!word.item_at_beginning) state_nxt = ST_STANDBY;
      end
      ST_METALCHK: begin
        state_nxt = word.metal_found ? ST_METAL : ST_NONMETAL;
      end
      ST_NONMETAL: begin
        if (word.item_at_end) state_nxt = ST_END;
        if (word.item_at_beginning || word.item_at_height_sensor) state_nxt = ST_ERROR;
      end
      ST_END: begin
        if (word.start_released) state_nxt = ST_STANDBY;
        if (!word.item_at_end) state_nxt = ST_READY;
        if (word.item_at_metal_sensor || word.item_at_height_sensor) state_nxt = ST_ERROR;
      end
      ST_METAL: begin
        if (word.passed_slide) state_nxt = ST_SLIDE;
        if (word.item_at_beginning || word.item_at_height_sensor) state_nxt = ST_ERROR;
      end
      ST_SLIDE: begin
        if (word.start_released) state_nxt = ST_STANDBY;
        if (word.item_at_beginning) state_nxt = ST_TRANSPORT;
        if (word.item_at_end || word.item_at_height_sensor) state_nxt = ST_ERROR;
      end
      ST_ERROR: begin
        if (word.start_released) state_nxt = ST_STANDBY;
      end
      default: begin
        state_nxt = ST_START;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/csc_out_decode.sv =====
// ----------------------------------------------------------------------------
// csc_out_decode: output decode of the new controller state
// Drives belt, lamps and mode; updates the held start LED and junction.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_out_decode
  import csc_pkg::*;
(
  input  ctl_state_t state_nxt,
  input  logic       blink_phase,
  input  logic       led_start_r,
  input  logic       junction_r,
  output out_word_t  word
);

  always_comb begin
    word               = '0;
    word.drive         = DRV_STOP;
    word.led_start     = led_start_r;
    word.junction_open = junction_r;
    word.mode          = 4'(state_nxt);
    case (state_nxt)
      ST_START, ST_STANDBY: begin
        word.led_start = 1'b1;
      end
      ST_READY: begin
        word.lamp_green = 1'b1;
        word.led_start  = 1'b1;
      end
      ST_TRANSPORT: begin
        word.drive      = DRV_RIGHT;
        word.lamp_green = 1'b1;
        word.led_start  = 1'b0;
      end
      ST_RETURN: begin
        word.drive    = DRV_LEFT;
        word.lamp_red = blink_phase;
      end
      ST_BACK: begin
        word.lamp_red = blink_phase;
      end
      ST_METALCHK: begin
        word.lamp_green = 1'b1;
      end
      ST_NONMETAL: begin
        word.drive         = DRV_RIGHT;
        word.lamp_green    = 1'b1;
        word.led_start     = 1'b0;
        word.junction_open = 1'b1;
      end
      ST_END: begin
        word.lamp_green    = blink_phase;
        word.led_start     = 1'b1;
        word.junction_open = 1'b0;
      end
      ST_METAL: begin
        word.drive       = DRV_RIGHT;
        word.lamp_yellow = 1'b1;
      end
      ST_SLIDE: begin
        word.lamp_green = 1'b1;
        word.led_start  = 1'b1;
      end
      default: begin
        // error
        word.lamp_red      = blink_phase;
        word.led_start     = 1'b1;
        word.junction_open = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/conveyor_sorting_controller.sv =====
// ----------------------------------------------------------------------------
// conveyor_sorting_controller: twelve-state conveyor sorting controller
// Steps the sorting sequence once per sensor word and reports belt drive,
// lamps, start LED, junction and the new state.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_word): one word per control
//   tick carrying the sensor flags, the start release, the profile verdict
//   and the blink phase. Result channel (out_valid / out_stall / out_word):
//   exactly one word per input word, in order.
//   Path: a word taken into the input register has its result loaded into
//   the output register once that register is empty or its word is taken,
//   and out_valid then rises. Throughput: one word per cycle when not stalled,
//   set by the single pass of transition and decode logic between the registers.
//   Reset (rst_n low, synchronous): controller goes to the start state,
//   start LED off, junction closed, both registers empty.
//   Receiver stall: the output register holds its word; the input register
//   still takes one more word, then in_stall rises until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module conveyor_sorting_controller
  import csc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  // input register
  logic       in_valid_r;
  in_word_t   in_word_r;
  // output register
  logic       out_valid_r;
  out_word_t  out_word_r;
  // controller state
  ctl_state_t state_r;
  logic       led_start_r;
  logic       junction_r;

  ctl_state_t state_nxt;
  out_word_t  res_word;
  logic       advance;

  // move the held word into the output register when that slot frees up
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  // hold the input side only while a word waits and the output cannot drain
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  csc_next_state u_next (
    .state     (state_r),
    .word      (in_word_r),
    .state_nxt (state_nxt)
  );

  csc_out_decode u_dec (
    .state_nxt   (state_nxt),
    .blink_phase (in_word_r.blink_phase),
    .led_start_r (led_start_r),
    .junction_r  (junction_r),
    .word        (res_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ST_START;
      led_start_r <= 1'b0;
      junction_r  <= 1'b0;
    end else begin
      // input register: load on accept, drop once the word advances
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      // output register: take the result, clear when taken with nothing behind
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
        led_start_r <= res_word.led_start;
        junction_r  <= res_word.junction_open;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_word_r <= in_word;
    end
    if (advance) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire
